@@ design/itee_pkg.sv @@
package itee_pkg;

  // sizes
  localparam int NUM_TIMERS = 16;
  localparam int TIME_BITS  = 48;
  localparam int ORDER_BITS = 40;
  localparam int ID_BITS    = 4;
  localparam int IVL_BITS   = 32;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W      = $clog2(NUM_TIMERS + 1);

  typedef logic [TIME_BITS-1:0]  time_t;
  typedef logic [ORDER_BITS-1:0] order_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  // request codes
  typedef enum logic [1:0] {
    REQ_ARM    = 2'd0,
    REQ_CANCEL = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  // result kinds
  typedef enum logic [1:0] {
    KIND_ARM     = 2'd0,
    KIND_CANCEL  = 2'd1,
    KIND_EXPIRED = 2'd2,
    KIND_IDLE    = 2'd3
  } kind_e;

endpackage

@@ design/interval_timer_expiry_engine_unit.sv @@
// arm and cancel: one result word in the cycle after the start pulse, busy stays low
// tick with the kept earliest deadline still ahead: one result word in the cycle after the start pulse
// tick past the earliest deadline: max(k,1) scan passes over all NUM_TIMERS slots for k due
//   timers, one word at the end of each pass, busy held until the last pass ends
// reset: all timers disarmed, arm counter zero, earliest deadline all ones
// results are strobed for one cycle by result_valid_o; the receiver cannot stall
module interval_timer_expiry_engine_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [1:0]                         req_type_i,
  input  logic [itee_pkg::ID_BITS-1:0]       timer_id_i,
  input  logic [itee_pkg::IVL_BITS-1:0]      interval_i,
  input  logic [itee_pkg::TIME_BITS-1:0]     now_i,
  output logic                               result_valid_o,
  output logic [itee_pkg::ID_BITS-1:0]       slot_id_o,
  output logic [1:0]                         kind_o,
  output logic                               was_armed_o,
  output logic                               last_o
);

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  localparam itee_pkg::idx_t IDX_MAX = itee_pkg::IDX_W'(itee_pkg::NUM_TIMERS - 1);

  state_e state_q;

  // timer store: deadline and arm number are only read while the slot is armed
  itee_pkg::time_t  deadline_q [itee_pkg::NUM_TIMERS];
  itee_pkg::order_t arm_ord_q  [itee_pkg::NUM_TIMERS];
  logic [itee_pkg::NUM_TIMERS-1:0] armed_q;
  itee_pkg::order_t order_cnt_q;
  itee_pkg::time_t  earliest_q;

  // scan context
  itee_pkg::time_t  now_q;
  itee_pkg::idx_t   idx_q;
  logic             found_q;
  itee_pkg::idx_t   best_idx_q;
  itee_pkg::order_t best_ord_q;
  itee_pkg::cnt_t   cnt_q;
  itee_pkg::time_t  emin_q;

  // result word register
  logic                         valid_q;
  logic [itee_pkg::ID_BITS-1:0] slot_q;
  itee_pkg::kind_e              kind_q;
  logic                         was_q;
  logic                         last_q;

  logic accept;
  logic id_ok;
  itee_pkg::idx_t id_idx;
  logic [itee_pkg::TIME_BITS:0] arm_sum;
  itee_pkg::time_t arm_dl;
  logic tick_idle;

  assign accept  = start_i && !busy_o;
  assign id_ok   = (32'(timer_id_i) < itee_pkg::NUM_TIMERS);
  assign id_idx  = itee_pkg::IDX_W'(timer_id_i);
  // deadline = now + interval, clamped at the largest time value on carry out
  assign arm_sum = {1'b0, now_i} + (itee_pkg::TIME_BITS + 1)'(interval_i);
  assign arm_dl  = arm_sum[itee_pkg::TIME_BITS] ? '1 : arm_sum[itee_pkg::TIME_BITS-1:0];
  // fast path: kept earliest deadline still in the future
  assign tick_idle = (earliest_q > now_i);

  // one slot per cycle through the shared compare path
  itee_pkg::time_t  cur_dl;
  itee_pkg::order_t cur_ord;
  logic             cur_due;
  logic             take;
  logic             found_n;
  itee_pkg::idx_t   best_idx_n;
  itee_pkg::order_t best_ord_n;
  itee_pkg::cnt_t   cnt_n;
  itee_pkg::time_t  emin_n;
  logic             scan_end;
  logic             tick_done;

  assign cur_dl  = deadline_q[idx_q];
  assign cur_ord = arm_ord_q[idx_q];
  assign cur_due = armed_q[idx_q] && (cur_dl <= now_q);
  // strict compare keeps the lower slot on equal arm numbers
  assign take    = cur_due && (!found_q || (cur_ord < best_ord_q));

  always_comb begin
    found_n    = found_q || cur_due;
    best_idx_n = take ? idx_q : best_idx_q;
    best_ord_n = take ? cur_ord : best_ord_q;
    cnt_n      = cnt_q + itee_pkg::CNT_W'(cur_due);
    // surviving timers set the new earliest deadline
    emin_n     = (armed_q[idx_q] && !cur_due && (cur_dl < emin_q)) ? cur_dl : emin_q;
  end

  assign scan_end  = (state_q == ST_SCAN) && (idx_q == IDX_MAX);
  // the tick ends on the pass that finds nothing or exactly one due timer
  assign tick_done = !found_n || (cnt_n == itee_pkg::CNT_W'(1));

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      armed_q     <= '0;
      order_cnt_q <= '0;
      earliest_q  <= '1;
      valid_q     <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      if (accept) begin
        unique case (req_type_i)
          itee_pkg::REQ_ARM: begin
            valid_q <= 1'b1;
            if (id_ok) begin
              armed_q[id_idx] <= 1'b1;
              order_cnt_q     <= order_cnt_q + 1'b1;
              if (arm_dl < earliest_q) begin
                earliest_q <= arm_dl;
              end
            end
          end
          itee_pkg::REQ_CANCEL: begin
            valid_q <= 1'b1;
            if (id_ok) begin
              armed_q[id_idx] <= 1'b0;
            end
          end
          itee_pkg::REQ_TICK: begin
            valid_q <= tick_idle;
            if (!tick_idle) begin
              state_q <= ST_SCAN;
            end
          end
          default: ;
        endcase
      end
      if (scan_end) begin
        valid_q <= 1'b1;
        if (found_n) begin
          armed_q[best_idx_n] <= 1'b0;
        end
        if (tick_done) begin
          earliest_q <= emin_n;
          state_q    <= ST_IDLE;
        end
      end
    end
  end

  // timer store, scan context and result word payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q    <= now_i;
      idx_q    <= '0;
      found_q  <= 1'b0;
      cnt_q    <= '0;
      emin_q   <= '1;
      slot_q   <= timer_id_i;
      was_q    <= 1'b0;
      last_q   <= 1'b1;
      kind_q   <= itee_pkg::KIND_IDLE;
      case (req_type_i)
        itee_pkg::REQ_ARM: begin
          kind_q <= itee_pkg::KIND_ARM;
          if (id_ok) begin
            deadline_q[id_idx] <= arm_dl;
            arm_ord_q[id_idx]  <= order_cnt_q;
          end
        end
        itee_pkg::REQ_CANCEL: begin
          kind_q <= itee_pkg::KIND_CANCEL;
          was_q  <= id_ok && armed_q[id_idx];
        end
        default: begin
          slot_q <= '0;
        end
      endcase
    end else if (state_q == ST_SCAN) begin
      idx_q      <= idx_q + 1'b1;
      found_q    <= found_n;
      best_idx_q <= best_idx_n;
      best_ord_q <= best_ord_n;
      cnt_q      <= cnt_n;
      emin_q     <= emin_n;
      if (scan_end) begin
        // start the next pass from scratch
        idx_q   <= '0;
        found_q <= 1'b0;
        cnt_q   <= '0;
        emin_q  <= '1;
        slot_q  <= found_n ? itee_pkg::ID_BITS'(best_idx_n) : '0;
        kind_q  <= found_n ? itee_pkg::KIND_EXPIRED : itee_pkg::KIND_IDLE;
        was_q   <= 1'b0;
        last_q  <= tick_done;
      end
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = valid_q;
  assign slot_id_o      = slot_q;
  assign kind_o         = kind_q;
  assign was_armed_o    = was_q;
  assign last_o         = last_q;

  // a non-final expired word leaves the scan running
  a_more_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy_o)
    else $error("non-final word while sequencer idle");

  // arm and cancel answer in the next cycle with a single word
  a_quick_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o &&
    (req_type_i == itee_pkg::REQ_ARM || req_type_i == itee_pkg::REQ_CANCEL)
    |=> result_valid_o && last_o)
    else $error("arm or cancel word missing");

  // only a cancel word can report an armed timer
  a_was_cancel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && was_armed_o |-> kind_o == itee_pkg::KIND_CANCEL)
    else $error("was_armed set outside cancel");

  // leaving the scan always goes with the final word
  a_scan_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o ##1 !busy_o |-> result_valid_o && last_o)
    else $error("scan ended without final word");

endmodule
